// ===== hw/rtl/dbs_pkg.sv =====
// Package for the depth background subtractor.
// Holds the beat structs, operation and register codes, and reset values.
// No dependencies.
package dbs_pkg;

  localparam int DEPTH_W = 16;
  localparam int INDEX_W = 17;
  localparam int MAXD_W  = 15;
  localparam int TOL_W   = 16;
  localparam int FRAME_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PIXEL_COUNT_DEFAULT = 76800;

  localparam logic [1:0] OP_CALIBRATE = 2'd0;
  localparam logic [1:0] OP_ELIMINATE = 2'd1;
  localparam logic [1:0] OP_RESTART   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_READING   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES       = 2'd3;

  localparam logic signed [DEPTH_W-1:0] NO_READING_RST   = 16'sd32767;
  localparam logic [MAXD_W-1:0]         MAX_DISTANCE_RST = 15'd400;
  localparam logic [TOL_W-1:0]          MATCH_TOL_RST    = 16'd50;
  localparam logic [FRAME_W-1:0]        FRAMES_RST       = 4'd10;
  localparam logic [FRAME_W-1:0]        FRAMES_MAX       = 4'd15;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [DEPTH_W-1:0] pixel_depth;
    logic [INDEX_W-1:0]        pixel_index;
    logic                      frame_last;
  } pix_beat_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth_out;
    logic                      calibration_done;
  } res_beat_t;

endpackage

// ===== hw/rtl/dbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Parameters set word width and depth. No dependencies.
module dbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/depth_background_subtractor.sv =====
// Depth background subtractor: per-pixel background learning and removal.
// The pixel beat and its RAM read are registered, then the result beat. One pixel per cycle
// unless the output stalls; the background RAM is read on accept and
// written when it advances, with a one-entry bypass for back-to-back pixels.
// Reset (rst, synchronous): frame count, valids and registers to defaults;
// background RAM is not cleared.
module depth_background_subtractor #(
  parameter int PIXEL_COUNT = dbs_pkg::PIXEL_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  dbs_pkg::pix_beat_t            pix,
  output logic                          res_valid,
  input  logic                          res_stall,
  output dbs_pkg::res_beat_t            res,
  input  logic                          cfg_we,
  input  logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbs_pkg::*;

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int EW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  // configuration
  logic signed [DEPTH_W-1:0] no_reading;
  logic [MAXD_W-1:0]         max_distance;
  logic [TOL_W-1:0]          match_tol;
  logic [FRAME_W-1:0]        frames_needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_reading    <= NO_READING_RST;
      max_distance  <= MAX_DISTANCE_RST;
      match_tol     <= MATCH_TOL_RST;
      frames_needed <= FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NO_READING:   no_reading    <= cfg_data;
        CFG_MAX_DISTANCE: max_distance  <= cfg_data[MAXD_W-1:0];
        CFG_MATCH_TOL:    match_tol     <= cfg_data[TOL_W-1:0];
        CFG_FRAMES:       frames_needed <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic pix_acc, out_free, s1_adv;
  logic s1_valid;
  pix_beat_t s1;

  assign out_free  = !res_valid || !res_stall;
  assign s1_adv    = s1_valid && out_free;
  assign pix_stall = s1_valid && !out_free;
  assign pix_acc   = pix_valid && !pix_stall;

  // background RAM
  logic [EW-1:0]      pix_idx_ext;
  logic [AW-1:0]      ram_raddr;
  logic               ram_we;
  logic [AW-1:0]      s1_addr;
  logic [DEPTH_W-1:0] ram_wdata, ram_rdata;

  assign pix_idx_ext = EW'(pix.pixel_index);
  assign ram_raddr   = pix_idx_ext[AW-1:0];

  dbs_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (PIXEL_COUNT)
  ) u_bg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (pix_acc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1 <= pix;
    end
  end

  // bypass of the last write
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [DEPTH_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= ram_wdata;
    end
  end

  // compute stage
  logic [FRAME_W-1:0]        frames_counted, frames_counted_next;
  logic [EW-1:0]             s1_idx_ext;
  logic                      in_range, calibrating;
  logic signed [DEPTH_W-1:0] bg, cur, ref_depth, result;
  logic signed [DEPTH_W:0]   diff;
  logic [DEPTH_W:0]          mag;
  logic signed [DEPTH_W:0]   depth_x, max_x;

  assign s1_idx_ext = EW'(s1.pixel_index);
  assign s1_addr    = s1_idx_ext[AW-1:0];
  assign in_range   = s1_idx_ext < EW'(PIXEL_COUNT);
  assign bg         = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
  assign depth_x    = {s1.pixel_depth[DEPTH_W-1], s1.pixel_depth};
  assign max_x      = {2'b00, max_distance};
  assign calibrating = frames_counted < frames_needed;

  always_comb begin
    frames_counted_next = frames_counted;
    ram_we    = 1'b0;
    cur       = (frames_counted == '0) ? no_reading : bg;
    ref_depth = in_range ? bg : no_reading;
    diff      = {ref_depth[DEPTH_W-1], ref_depth} - depth_x;
    mag       = diff[DEPTH_W] ? (DEPTH_W+1)'(0) - diff : diff;
    result    = s1.pixel_depth;
    if (cur == no_reading && depth_x < max_x) begin
      cur = s1.pixel_depth;
    end
    case (s1.operation)
      OP_CALIBRATE: begin
        if (calibrating) begin
          ram_we = s1_adv && in_range;
          if (s1.frame_last && frames_counted != FRAMES_MAX) begin
            frames_counted_next = frames_counted + 1'b1;
          end
        end
      end
      OP_ELIMINATE: begin
        if (s1.pixel_depth != no_reading &&
            (mag < {1'b0, match_tol} || depth_x > max_x)) begin
          result = no_reading;
        end
      end
      OP_RESTART: frames_counted_next = '0;
      default: ;
    endcase
  end

  assign ram_wdata = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_counted <= '0;
    end else if (s1_adv) begin
      frames_counted <= frames_counted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res.depth_out        <= result;
      res.calibration_done <= frames_counted_next >= frames_needed;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> s1_valid && res_valid)
    else $error("pixel stall without a held beat");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(frames_counted))
    else $error("frame count moved without a beat");

  a_write_on_calibrate: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s1_adv && s1.operation == OP_CALIBRATE && in_range)
    else $error("background write outside calibrate");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("result beat lost");

endmodule
